[src/assert_macros.svh]
// Assertion macros shared by the RTL of the delta varint address lookup.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define DVAL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define DVAL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/dval_pkg.sv]
`timescale 1ns / 1ps
// Package for the delta varint address lookup: widths, register codes, types.
// No dependencies; used by dval_seg_check and delta_varint_address_lookup.
package dval_pkg;

  localparam int SEGMENT_SLOTS = 3;   // segments actually checked
  localparam int SEG_REGS      = 3;   // segment register pairs in the map
  localparam int INDEX_BITS    = 20;  // entry counter width, saturating

  localparam int ADDR_W   = 32;
  localparam int BYTE_W   = 8;
  localparam int REM_W    = 31;       // remainder never holds a negative value
  localparam int OUT_IDX_W = 20;
  localparam int OUT_OFF_W = 31;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int SEG_CNT_W = 2;

  localparam int IN_DATA_W  = 40;     // query_address + table_byte
  localparam int OUT_DATA_W = 56;     // hit + entry_index + entry_offset, padded

  localparam int VARINT_BITS = 7;
  localparam logic [BYTE_W-1:0] VARINT_MASK = 8'h7f;
  localparam logic [BYTE_W-1:0] VARINT_MORE = 8'h80;

  typedef logic [ADDR_W-1:0] word_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIRST_ADDR = 3'd0,
    REG_SEG_COUNT  = 3'd1,
    REG_SEG0_BASE  = 3'd2,
    REG_SEG0_LEN   = 3'd3,
    REG_SEG1_BASE  = 3'd4,
    REG_SEG1_LEN   = 3'd5,
    REG_SEG2_BASE  = 3'd6,
    REG_SEG2_LEN   = 3'd7
  } cfg_reg_t;

  // Outcome of the pass-start check for one query.
  typedef struct packed {
    logic             miss;       // outside every segment or below first_address
    logic [REM_W-1:0] remainder;  // query - first_address when not a miss
  } seg_res_t;

endpackage

[src/delta_varint_address_lookup.sv]
`timescale 1ns / 1ps
// Top level of the delta varint address lookup.
// Depends on dval_pkg, dval_seg_check and assert_macros.svh.
//
// Usage: each lookup pass streams the bytes of a delta table on the input
// channel, one byte per beat. in_tdata carries the query address and the byte,
// in_tuser marks the first byte of a pass and in_tlast its final byte. Deltas
// are big-endian base-128 varints; bit 7 of a byte means more bytes follow.
// The first byte checks the query against the configured segments and
// subtracts first_address; each completed delta is subtracted in turn until
// the remainder would go negative. Exactly one result beat leaves per pass:
// hit, entry index and offset, or a miss with zeros.
// Throughput: one byte per cycle while the result channel is not stalled. The
// accepted beat sits in an input register (segment check done on the way in);
// when it moves on it updates the varint state and loads the result register,
// which drives out_tvalid. Bytes after the decision produce nothing.
// Stall: while out_tvalid is high and out_tready low, the input register holds
// and in_tready drops once it is full; nothing is lost.
// Reset (rst_n low at a clock edge) clears the configuration and walk state,
// empties both stages and leaves the block idle until the next pass start.
// Configuration is written through cfg_we/cfg_index/cfg_wdata between passes.
`include "assert_macros.svh"

module delta_varint_address_lookup (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [dval_pkg::IN_DATA_W-1:0]      in_tdata,  // [31:0] query_address, [39:32] table_byte
  input  logic                                in_tuser,  // [0] pass_start
  input  logic                                in_tlast,  // pass_end
  // result channel
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [dval_pkg::OUT_DATA_W-1:0]     out_tdata, // [0] hit, [20:1] entry_index,
                                                          // [51:21] entry_offset, [55:52] zero
  // configuration
  input  logic                                cfg_we,
  input  logic [dval_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dval_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  // configuration registers
  dval_pkg::word_t                 first_addr_r;
  logic [dval_pkg::SEG_CNT_W-1:0]  seg_count_r;
  dval_pkg::word_t                 seg_base_r [dval_pkg::SEG_REGS];
  dval_pkg::word_t                 seg_len_r  [dval_pkg::SEG_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_addr_r <= '0;
      seg_count_r  <= '0;
      for (int i = 0; i < dval_pkg::SEG_REGS; i++) begin
        seg_base_r[i] <= '0;
        seg_len_r[i]  <= '0;
      end
    end else if (cfg_we) begin
      unique case (dval_pkg::cfg_reg_t'(cfg_index))
        dval_pkg::REG_FIRST_ADDR: first_addr_r  <= cfg_wdata;
        dval_pkg::REG_SEG_COUNT:  seg_count_r   <= cfg_wdata[dval_pkg::SEG_CNT_W-1:0];
        dval_pkg::REG_SEG0_BASE:  seg_base_r[0] <= cfg_wdata;
        dval_pkg::REG_SEG0_LEN:   seg_len_r[0]  <= cfg_wdata;
        dval_pkg::REG_SEG1_BASE:  seg_base_r[1] <= cfg_wdata;
        dval_pkg::REG_SEG1_LEN:   seg_len_r[1]  <= cfg_wdata;
        dval_pkg::REG_SEG2_BASE:  seg_base_r[2] <= cfg_wdata;
        dval_pkg::REG_SEG2_LEN:   seg_len_r[2]  <= cfg_wdata;
      endcase
    end
  end

  // ---------------- input stage ----------------
  dval_pkg::seg_res_t seg_res;

  dval_seg_check u_seg_check (
    .query         (in_tdata[dval_pkg::ADDR_W-1:0]),
    .first_address (first_addr_r),
    .seg_count     (seg_count_r),
    .seg_base      (seg_base_r),
    .seg_length    (seg_len_r),
    .res           (seg_res)
  );

  logic                         s1_valid_r, s1_valid_nxt;
  logic                         s1_ps_r, s1_pe_r;
  logic [dval_pkg::BYTE_W-1:0]  s1_byte_r;
  dval_pkg::seg_res_t           s1_seg_r;
  logic                         in_fire, s1_fire;
  logic                         out_valid_r, out_valid_nxt;
  logic [dval_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  assign s1_fire   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire)      s1_valid_nxt = 1'b1;
    else if (s1_fire) s1_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else        s1_valid_r <= s1_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_ps_r   <= in_tuser;
      s1_pe_r   <= in_tlast;
      s1_byte_r <= in_tdata[dval_pkg::ADDR_W +: dval_pkg::BYTE_W];
      s1_seg_r  <= seg_res;
    end
  end

  // ---------------- varint walk ----------------
  logic [dval_pkg::REM_W-1:0]      rem_r, rem_nxt, rem_cur;
  dval_pkg::word_t                 pd_r, pd_nxt, pd_new;
  logic [dval_pkg::INDEX_BITS-1:0] cnt_r, cnt_nxt, cnt_cur;
  logic                            decided_r, decided_nxt, decided_cur;
  dval_pkg::word_t                 rem_diff;
  logic                            emit, emit_hit;
  logic [dval_pkg::OUT_IDX_W-1:0]  hit_index;

  assign pd_new   = {pd_r[dval_pkg::ADDR_W-dval_pkg::VARINT_BITS-1:0] & {(dval_pkg::ADDR_W
                    - dval_pkg::VARINT_BITS){!s1_ps_r}},
                     s1_byte_r[dval_pkg::VARINT_BITS-1:0] &
                     dval_pkg::VARINT_MASK[dval_pkg::VARINT_BITS-1:0]};
  assign rem_diff = {1'b0, rem_cur} - pd_new;
  assign hit_index = dval_pkg::OUT_IDX_W'(cnt_cur);

  always_comb begin
    rem_cur     = s1_ps_r ? s1_seg_r.remainder : rem_r;
    cnt_cur     = s1_ps_r ? '0 : cnt_r;
    decided_cur = s1_ps_r ? 1'b0 : decided_r;

    rem_nxt     = rem_r;
    pd_nxt      = pd_r;
    cnt_nxt     = cnt_r;
    decided_nxt = decided_r;
    emit        = 1'b0;
    emit_hit    = 1'b0;

    if (s1_fire) begin
      if (s1_ps_r) begin
        pd_nxt      = '0;
        cnt_nxt     = '0;
        decided_nxt = 1'b0;
        rem_nxt     = s1_seg_r.remainder;
      end
      if (s1_ps_r && s1_seg_r.miss) begin
        emit        = 1'b1;
        decided_nxt = 1'b1;
      end else if (!decided_cur) begin
        if ((s1_byte_r & dval_pkg::VARINT_MORE) != '0) begin
          // more bytes of this delta follow
          pd_nxt = pd_new;
          if (s1_pe_r) begin
            emit        = 1'b1;
            decided_nxt = 1'b1;
          end
        end else begin
          pd_nxt = '0;
          if (rem_diff[dval_pkg::ADDR_W-1]) begin
            // delta overshoots: current entry covers the query,
            // except on the final byte, which reports a miss
            emit        = 1'b1;
            emit_hit    = !s1_pe_r;
            decided_nxt = 1'b1;
          end else begin
            rem_nxt = rem_diff[dval_pkg::REM_W-1:0];
            cnt_nxt = (cnt_cur == '1) ? cnt_cur : cnt_cur + 1'b1;
            if (s1_pe_r) begin
              emit        = 1'b1;
              decided_nxt = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r     <= '0;
      pd_r      <= '0;
      cnt_r     <= '0;
      decided_r <= 1'b1;
    end else begin
      rem_r     <= rem_nxt;
      pd_r      <= pd_nxt;
      cnt_r     <= cnt_nxt;
      decided_r <= decided_nxt;
    end
  end

  // ---------------- result register ----------------
  always_comb begin
    out_data_nxt = out_data_r;
    if (emit) begin
      out_data_nxt = '0;
      if (emit_hit) begin
        out_data_nxt[0] = 1'b1;
        out_data_nxt[1 +: dval_pkg::OUT_IDX_W] = hit_index;
        out_data_nxt[1 + dval_pkg::OUT_IDX_W +: dval_pkg::OUT_OFF_W] = rem_cur;
      end
    end
    out_valid_nxt = out_valid_r;
    if (emit)            out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---------------- assertions ----------------
  `DVAL_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_valid_r && !s1_valid_r,
    "reset left a stage full")
  `DVAL_ASSERT(a_miss_zero, out_valid_r && !out_data_r[0] |->
    out_data_r[dval_pkg::OUT_DATA_W-1:1] == '0, "miss carries nonzero fields")
  `DVAL_ASSERT(a_seg_miss, s1_fire && s1_ps_r && s1_seg_r.miss |=>
    out_valid_r && !out_data_r[0], "segment miss did not produce a miss beat")
  `DVAL_ASSERT(a_decided_quiet, s1_fire && !s1_ps_r && decided_r |-> !emit,
    "result emitted after the pass was decided")
  `DVAL_ASSERT(a_emit_decides, emit |=> decided_r, "pass not closed after its result")

endmodule

[src/dval_seg_check.sv]
`timescale 1ns / 1ps
// Segment range check and base subtraction for the query address.
// Depends on dval_pkg.
module dval_seg_check (
  input  dval_pkg::word_t                      query,
  input  dval_pkg::word_t                      first_address,
  input  logic [dval_pkg::SEG_CNT_W-1:0]       seg_count,
  input  dval_pkg::word_t                      seg_base [dval_pkg::SEG_REGS],
  input  dval_pkg::word_t                      seg_length [dval_pkg::SEG_REGS],
  output dval_pkg::seg_res_t                   res
);

  logic [dval_pkg::SEG_CNT_W-1:0] n_active;
  logic [dval_pkg::SEG_REGS-1:0]  seg_hit;
  dval_pkg::word_t                seg_end [dval_pkg::SEG_REGS];
  dval_pkg::word_t                diff;

  assign n_active = (32'(seg_count) > dval_pkg::SEGMENT_SLOTS)
                  ? dval_pkg::SEG_CNT_W'(dval_pkg::SEGMENT_SLOTS) : seg_count;

  always_comb begin
    for (int i = 0; i < dval_pkg::SEG_REGS; i++) begin
      // end of range wraps at 32 bits
      seg_end[i] = seg_base[i] + seg_length[i];
      seg_hit[i] = (dval_pkg::SEG_CNT_W'(i) < n_active) &&
                   (query >= seg_base[i]) && (query < seg_end[i]);
    end
  end

  assign diff          = query - first_address;
  assign res.miss      = !(|seg_hit) || diff[dval_pkg::ADDR_W-1];
  assign res.remainder = diff[dval_pkg::REM_W-1:0];

endmodule
